/* hdl/jded_pkg.sv */
// Shared types and constants of the joint distance extremum detector.
package jded_pkg;

    // Field widths
    localparam int COORD_BITS       = 12;
    localparam int FRAME_INDEX_BITS = 16;
    localparam int SQ_BITS          = 2 * COORD_BITS;
    localparam int DIST_BITS        = SQ_BITS + 1;

    // Sliding window of past distances and the judging rule
    localparam int WINDOW_DEPTH  = 4;
    localparam int JUDGE_MIN     = 4;   // frames needed before the first judgment
    localparam int CENTER_OFFSET = 2;   // judged frame sits two places back

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Input item: two keypoints and the sequence start flag
    typedef struct packed {
        logic [COORD_BITS-1:0] first_x;
        logic [COORD_BITS-1:0] first_y;
        logic [COORD_BITS-1:0] second_x;
        logic [COORD_BITS-1:0] second_y;
        logic                  start_sequence;
    } jded_in_t;

    // Result item: one detected extremum
    typedef struct packed {
        logic [FRAME_INDEX_BITS-1:0] frame_index;
        logic                        is_peak;
        logic [DIST_BITS-1:0]        distance_squared;
    } jded_out_t;

    // Queue entry: the two squared axis differences of one frame
    typedef struct packed {
        logic [SQ_BITS-1:0] sq_x;
        logic [SQ_BITS-1:0] sq_y;
        logic               start_sequence;
    } jded_sq_t;

endpackage

/* hdl/joint_distance_extremum_detector_unit.sv */
// Top level of the joint distance extremum detector.
//
// Takes one frame (two keypoints) per cycle and reports frames whose squared
// keypoint distance is a strict maximum or minimum of the five-frame window
// centered on it. A frame is judged when the second frame after it arrives,
// so frames 0 and 1 and the last two of a sequence are never reported;
// start_sequence clears the window and restarts the frame count. The frame
// counter saturates and reporting stops once it does. Sustained rate is one
// item per cycle while each result is taken at once. A result passes through
// the front square register, the queue and the result register, in order.
// The queue (QUEUE_DEPTH entries) plus the front register absorb up to
// QUEUE_DEPTH + 1 items of back-pressure while a result waits to be taken.
module joint_distance_extremum_detector_unit #(
    parameter int QUEUE_DEPTH = jded_pkg::QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  jded_pkg::jded_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output jded_pkg::jded_out_t m_data
);
    import jded_pkg::*;

    logic     push, q_full, pop, q_not_empty;
    jded_sq_t push_data, q_head;

    jded_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    jded_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    jded_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

/* hdl/jded_front.sv */
// Front part: accepts frames and squares the axis differences.
module jded_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  jded_pkg::jded_in_t s_data,
    output logic              push,
    output jded_pkg::jded_sq_t push_data,
    input  logic              q_full
);
    import jded_pkg::*;

    logic                  valid_reg, valid_next;
    jded_sq_t              sq_reg, sq_next;
    logic [COORD_BITS-1:0] dx, dy;
    logic                  s_fire;

    // Stage is free when empty or when its item moves into the queue
    assign push    = valid_reg && !q_full;
    assign s_ready = !valid_reg || !q_full;
    assign s_fire  = s_valid && s_ready;
    assign push_data = sq_reg;

    // Absolute axis differences and their squares
    always_comb begin
        dx = (s_data.first_x >= s_data.second_x) ? (s_data.first_x - s_data.second_x)
                                                 : (s_data.second_x - s_data.first_x);
        dy = (s_data.first_y >= s_data.second_y) ? (s_data.first_y - s_data.second_y)
                                                 : (s_data.second_y - s_data.first_y);
        sq_next.sq_x = SQ_BITS'(dx) * SQ_BITS'(dx);
        sq_next.sq_y = SQ_BITS'(dy) * SQ_BITS'(dy);
        sq_next.start_sequence = s_data.start_sequence;
    end

    always_comb begin
        valid_next = valid_reg;
        if (s_fire) begin
            valid_next = 1'b1;
        end else if (push) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            sq_reg <= sq_next;
        end
    end

endmodule

/* hdl/jded_queue.sv */
// Short first-in first-out queue between the front and back parts.
module jded_queue #(
    parameter int DEPTH = jded_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  jded_pkg::jded_sq_t push_data,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output jded_pkg::jded_sq_t head
);
    import jded_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    jded_sq_t              entry_reg [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic                  do_push, do_pop;

    assign full      = (count_reg == CNT_BITS'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Pointer wrap and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hdl/jded_back.sv */
// Back part: distance window, frame counter, extremum test and result register.
module jded_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_not_empty,
    input  jded_pkg::jded_sq_t q_head,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output jded_pkg::jded_out_t m_data
);
    import jded_pkg::*;

    logic [DIST_BITS-1:0]        window_reg [WINDOW_DEPTH];
    logic [DIST_BITS-1:0]        window_next [WINDOW_DEPTH];
    logic [DIST_BITS-1:0]        base [WINDOW_DEPTH];
    logic [FRAME_INDEX_BITS-1:0] counter_reg, counter_next, counter_base;
    logic                        m_valid_reg, m_valid_next;
    jded_out_t                   m_data_reg, m_data_next;
    logic [DIST_BITS-1:0]        new_dist, c;
    logic                        judged, peak, valley;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign pop     = q_not_empty && (!m_valid_reg || m_ready);

    // Distance of the new frame and the window as seen after a possible start
    always_comb begin
        new_dist = DIST_BITS'(q_head.sq_x) + DIST_BITS'(q_head.sq_y);
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            base[i] = q_head.start_sequence ? '0 : window_reg[i];
        end
        counter_base = q_head.start_sequence ? '0 : counter_reg;
    end

    // Strict extremum test on the frame two places back
    always_comb begin
        c      = base[CENTER_OFFSET];
        judged = (counter_base >= FRAME_INDEX_BITS'(JUDGE_MIN)) && (counter_base != '1);
        peak   = (c > base[0]) && (c > base[1]) && (c > base[3]) && (c > new_dist);
        valley = (c < base[0]) && (c < base[1]) && (c < base[3]) && (c < new_dist);
        m_data_next.frame_index      = counter_base - FRAME_INDEX_BITS'(CENTER_OFFSET);
        m_data_next.is_peak          = peak;
        m_data_next.distance_squared = c;
    end

    // Window shift, saturating counter and result register update
    always_comb begin
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            window_next[i] = window_reg[i];
        end
        counter_next = counter_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (pop) begin
            for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
                window_next[i] = base[i + 1];
            end
            window_next[WINDOW_DEPTH-1] = new_dist;
            counter_next = (counter_base == '1) ? counter_base : counter_base + 1'b1;
            m_valid_next = judged && (peak || valley);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                window_reg[i] <= '0;
            end
            counter_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                window_reg[i] <= window_next[i];
            end
            counter_reg <= counter_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule
